/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every edge outside reset.
`define LRU_PR_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("lru_pr assertion failed");

// Antecedent at one edge implies consequent at the next.
`define LRU_PR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("lru_pr assertion failed");

`endif

/* rtl/core/lru_pr_pkg.sv */
`default_nettype none
package lru_pr_pkg;

	localparam int FRAMES    = 8;
	localparam int PAGE_BITS = 16;
	localparam int FRAME_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int RANK_W    = FRAME_W;
	// wide enough to hold FRAMES itself
	localparam int CNT_W     = $clog2(FRAMES + 1);
	localparam int CFG_W     = 4;
	localparam int FAULT_W   = 16;

	localparam logic [CFG_W-1:0]   CFG_RESET = 4'd8;
	localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

	// running result handed from cell to cell
	typedef struct packed {
		logic               hit_found;
		logic [FRAME_W-1:0] hit_idx;
		logic [RANK_W-1:0]  hit_rank;
		logic               empty_found;
		logic [FRAME_W-1:0] empty_idx;
		logic [RANK_W-1:0]  best_rank;
		logic [FRAME_W-1:0] best_idx;
		logic [PAGE_BITS-1:0] best_page;
	} lru_pr_chain_t;

	// broadcast from the top level to every cell
	typedef struct packed {
		logic [PAGE_BITS-1:0] req_page;
		logic [CNT_W-1:0]     n_active;
		logic                 update;
		logic                 write_page;
		logic [FRAME_W-1:0]   chosen_idx;
		logic [CNT_W-1:0]     old_rank;
	} lru_pr_bcast_t;

endpackage
`default_nettype wire

/* rtl/core/lru_pr_if.sv */
`default_nettype none
interface lru_pr_req_if import lru_pr_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [PAGE_BITS-1:0] page;

	modport source (output valid, output page, input ready);
	modport sink (input valid, input page, output ready);
endinterface

interface lru_pr_rsp_if import lru_pr_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 hit;
	logic [FRAME_W-1:0]   frame;
	logic                 evicted_valid;
	logic [PAGE_BITS-1:0] evicted_page;
	logic [FAULT_W-1:0]   fault_count;

	modport source (output valid, output hit, output frame, output evicted_valid,
		output evicted_page, output fault_count, input ready);
	modport sink (input valid, input hit, input frame, input evicted_valid,
		input evicted_page, input fault_count, output ready);
endinterface

interface lru_pr_cfg_if import lru_pr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] frames_in_use;

	modport source (output valid, output frames_in_use, input ready);
	modport sink (input valid, input frames_in_use, output ready);
endinterface
`default_nettype wire

/* rtl/core/lru_pr_cell.sv */
`default_nettype none
module lru_pr_cell import lru_pr_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [FRAME_W-1:0] cell_idx,
	input  wire lru_pr_bcast_t bcast,
	input  wire lru_pr_chain_t chain_in,
	output lru_pr_chain_t      chain_out
);

	logic [PAGE_BITS-1:0] page_q;
	logic                 valid_q;
	logic [RANK_W-1:0]    rank_q;
	logic                 active;
	logic                 match;
	logic                 is_chosen;

	assign active    = CNT_W'(cell_idx) < bcast.n_active;
	assign match     = active && valid_q && (page_q == bcast.req_page);
	assign is_chosen = (cell_idx == bcast.chosen_idx);

	always_comb begin
		chain_out = chain_in;
		if (!chain_in.hit_found && match) begin
			chain_out.hit_found = 1'b1;
			chain_out.hit_idx   = cell_idx;
			chain_out.hit_rank  = rank_q;
		end
		if (!chain_in.empty_found && active && !valid_q) begin
			chain_out.empty_found = 1'b1;
			chain_out.empty_idx   = cell_idx;
		end
		// cell 0 seeds the oldest-frame search
		if (active && ((rank_q > chain_in.best_rank) || (cell_idx == '0))) begin
			chain_out.best_rank = rank_q;
			chain_out.best_idx  = cell_idx;
			chain_out.best_page = page_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q  <= '0;
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (bcast.update) begin
			if (is_chosen) begin
				valid_q <= 1'b1;
				rank_q  <= '0;
				if (bcast.write_page) begin
					page_q <= bcast.req_page;
				end
			end else if (valid_q && (CNT_W'(rank_q) < bcast.old_rank)) begin
				rank_q <= rank_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/core/lru_page_replacement_unit.sv */
`default_nettype none
// Fully associative LRU page replacement over FRAMES frames. Each word on req
// is one page reference; each word on rsp reports hit or fault, the frame
// now holding the page, the page evicted (zero if none) and the saturating
// fault count since reset. A fault fills the lowest empty frame in use and
// otherwise evicts the least recently used one. frames_in_use (written on
// cfg, always ready) limits lookup and replacement to frames 0..n-1; zero
// acts as 1 and values above FRAMES as FRAMES. Frames above the limit keep
// their contents. Write cfg only while no reference is outstanding.
// Throughput: one reference per clock; the result appears in the cycle after
// acceptance in an output register, and req stays ready while that register
// is empty or being drained. The cycle is set by the ripple through the row
// of frame cells, which resolves first hit, first empty frame and oldest
// frame in a single pass. No clearing pass after reset.
module lru_page_replacement_unit import lru_pr_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	lru_pr_req_if.sink   req,
	lru_pr_rsp_if.source rsp,
	lru_pr_cfg_if.sink   cfg
);

	logic [CFG_W-1:0]   frames_in_use_q;
	logic [CNT_W-1:0]   n_active;
	logic [FAULT_W-1:0] fault_q;
	logic [FAULT_W-1:0] fault_next;
	logic               accept;
	logic               miss;
	logic               evict;
	logic [FRAME_W-1:0] chosen;
	lru_pr_bcast_t      bcast;
	lru_pr_chain_t      chain [FRAMES+1];

	// output register
	logic                 out_valid_q;
	logic                 hit_q;
	logic [FRAME_W-1:0]   frame_q;
	logic                 evicted_valid_q;
	logic [PAGE_BITS-1:0] evicted_page_q;
	logic [FAULT_W-1:0]   fault_count_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use_q <= CFG_RESET;
		end else if (cfg.valid) begin
			frames_in_use_q <= cfg.frames_in_use;
		end
	end

	// clamp to 1..FRAMES
	always_comb begin
		if (frames_in_use_q == '0) begin
			n_active = CNT_W'(1);
		end else if (int'(frames_in_use_q) > FRAMES) begin
			n_active = CNT_W'(FRAMES);
		end else begin
			n_active = CNT_W'(frames_in_use_q);
		end
	end

	assign req.ready = !out_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	// row of frame cells; chain[0] is the empty search state
	assign chain[0] = '0;

	for (genvar g = 0; g < FRAMES; g++) begin : g_cell
		lru_pr_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cell_idx  (FRAME_W'(g)),
			.bcast     (bcast),
			.chain_in  (chain[g]),
			.chain_out (chain[g+1])
		);
	end

	// hit first, then lowest empty frame, then oldest frame
	assign miss  = !chain[FRAMES].hit_found;
	assign evict = miss && !chain[FRAMES].empty_found;

	always_comb begin
		if (!miss) begin
			chosen         = chain[FRAMES].hit_idx;
			bcast.old_rank = CNT_W'(chain[FRAMES].hit_rank);
		end else if (!evict) begin
			chosen         = chain[FRAMES].empty_idx;
			bcast.old_rank = CNT_W'(FRAMES);  // empty frame: every valid frame ages
		end else begin
			chosen         = chain[FRAMES].best_idx;
			bcast.old_rank = CNT_W'(chain[FRAMES].best_rank);
		end
		bcast.req_page   = req.page;
		bcast.n_active   = n_active;
		bcast.update     = accept;
		bcast.write_page = miss;
		bcast.chosen_idx = chosen;
	end

	assign fault_next = (miss && (fault_q != FAULT_MAX)) ? fault_q + 1'b1 : fault_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_q <= '0;
		end else if (accept) begin
			fault_q <= fault_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_q           <= !miss;
			frame_q         <= chosen;
			evicted_valid_q <= evict;
			evicted_page_q  <= evict ? chain[FRAMES].best_page : '0;
			fault_count_q   <= fault_next;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.hit           = hit_q;
	assign rsp.frame         = frame_q;
	assign rsp.evicted_valid = evicted_valid_q;
	assign rsp.evicted_page  = evicted_page_q;
	assign rsp.fault_count   = fault_count_q;

endmodule
`default_nettype wire

/* rtl/core/lru_pr_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module lru_pr_checker import lru_pr_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 rsp_valid,
	input wire logic                 rsp_ready,
	input wire logic                 rsp_hit,
	input wire logic                 rsp_evicted_valid,
	input wire logic [PAGE_BITS-1:0] rsp_evicted_page,
	input wire logic [FAULT_W-1:0]   rsp_fault_count
);

	// an eviction only comes with a fault
	`LRU_PR_ASSERT(a_evict_on_fault, clk, arst_n, !(rsp_valid && rsp_hit && rsp_evicted_valid))
	// no eviction reads as page zero
	`LRU_PR_ASSERT(a_evict_page_zero, clk, arst_n,
		!(rsp_valid && !rsp_evicted_valid) || (rsp_evicted_page == '0))
	// a fault is always counted
	`LRU_PR_ASSERT(a_fault_counted, clk, arst_n, !(rsp_valid && !rsp_hit) || (rsp_fault_count != '0))
	// a stalled word holds
	`LRU_PR_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready,
		rsp_valid && $stable(rsp_fault_count) && $stable(rsp_hit))

endmodule

bind lru_page_replacement_unit lru_pr_checker u_lru_pr_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_hit           (rsp.hit),
	.rsp_evicted_valid (rsp.evicted_valid),
	.rsp_evicted_page  (rsp.evicted_page),
	.rsp_fault_count   (rsp.fault_count)
);
`default_nettype wire

/* tb/lru_fault_check_pkg.sv */
package lru_fault_check_pkg;
	import lru_pr_pkg::*;

	typedef struct packed {
		logic                 hit;
		logic [FRAME_W-1:0]   frame;
		logic                 evicted_valid;
		logic [PAGE_BITS-1:0] evicted_page;
		logic [FAULT_W-1:0]   fault_count;
	} lookup_result_t;

	// Shadow copy of the frame table; every accepted reference queues the lookup
	// result the block has to return for it.
	class lru_tracker;
		logic [PAGE_BITS-1:0] page_of [FRAMES];
		bit                   held [FRAMES];
		int unsigned          age [FRAMES];
		logic [FAULT_W-1:0]   faults;
		logic [CFG_W-1:0]     frames_cfg;
		lookup_result_t       due_lookups [$];
		int unsigned          mismatches;
		int unsigned          checked;
		int unsigned          hits;
		int unsigned          evictions;

		function new();
			foreach (page_of[i]) begin
				page_of[i] = '0;
				held[i] = 1'b0;
				age[i] = 0;
			end
			faults = '0;
			frames_cfg = CFG_RESET;
			mismatches = 0;
			checked = 0;
			hits = 0;
			evictions = 0;
		endfunction

		function void set_frames(logic [CFG_W-1:0] n);
			frames_cfg = n;
		endfunction

		// zero acts as one frame, anything above FRAMES as FRAMES
		function int active_frames();
			if (frames_cfg == 0)
				return 1;
			if (frames_cfg > FRAMES)
				return FRAMES;
			return int'(frames_cfg);
		endfunction

		function int pending();
			return due_lookups.size();
		endfunction

		function void note_reference(logic [PAGE_BITS-1:0] pg);
			lookup_result_t want;
			int n;
			int slot;
			bit found;
			bit empty;
			int unsigned oldest;
			int unsigned prior;
			want = '0;
			n = active_frames();
			slot = 0;
			found = 1'b0;
			empty = 1'b0;
			for (int i = 0; i < n; i++) begin
				if (!found && held[i] && page_of[i] == pg) begin
					found = 1'b1;
					slot = i;
				end
			end
			if (!found) begin
				if (faults != FAULT_MAX)
					faults++;
				for (int i = 0; i < n; i++) begin
					if (!empty && !held[i]) begin
						empty = 1'b1;
						slot = i;
					end
				end
				if (!empty) begin
					// strict compare keeps the lowest index on a tie
					oldest = 0;
					slot = 0;
					for (int i = 0; i < n; i++) begin
						if (age[i] > oldest) begin
							oldest = age[i];
							slot = i;
						end
					end
					want.evicted_valid = 1'b1;
					want.evicted_page = page_of[slot];
				end
				page_of[slot] = pg;
			end
			prior = held[slot] ? age[slot] : FRAMES;
			for (int i = 0; i < FRAMES; i++) begin
				if (i != slot && held[i] && age[i] < prior)
					age[i]++;
			end
			age[slot] = 0;
			held[slot] = 1'b1;
			want.hit = found;
			want.frame = FRAME_W'(slot);
			want.fault_count = faults;
			due_lookups.push_back(want);
		endfunction

		function void check_lookup(logic h, logic [FRAME_W-1:0] f, logic ev,
				logic [PAGE_BITS-1:0] ep, logic [FAULT_W-1:0] fc);
			lookup_result_t want;
			if (due_lookups.size() == 0) begin
				$error("result word with no reference outstanding: hit=%0b frame=%0d", h, f);
				mismatches++;
				return;
			end
			want = due_lookups.pop_front();
			checked++;
			if (want.hit)
				hits++;
			if (want.evicted_valid)
				evictions++;
			if (h !== want.hit) begin
				$error("hit: expected %0b, actual %0b", want.hit, h);
				mismatches++;
			end
			if (f !== want.frame) begin
				$error("frame: expected %0d, actual %0d", want.frame, f);
				mismatches++;
			end
			if (ev !== want.evicted_valid) begin
				$error("evicted_valid: expected %0b, actual %0b", want.evicted_valid, ev);
				mismatches++;
			end
			if (ep !== want.evicted_page) begin
				$error("evicted_page: expected 0x%04h, actual 0x%04h", want.evicted_page, ep);
				mismatches++;
			end
			if (fc !== want.fault_count) begin
				$error("fault_count: expected %0d, actual %0d", want.fault_count, fc);
				mismatches++;
			end
		endfunction
	endclass

endpackage

/* tb/tb_lru_page_replacement_unit.sv */
module tb_lru_page_replacement_unit import lru_pr_pkg::*, lru_fault_check_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	// cycles without any accepted word before the run is declared hung
	localparam int QUIET_LIMIT  = 1000;
	// receiver hold-off, long enough to back the block up into req
	localparam int HOLDOFF_LEN  = 60;
	localparam int IDLE_PCT     = 28;
	localparam int PAGE_POOL    = 16;

	logic clk;
	logic arst_n;

	lru_pr_req_if req_if ();
	lru_pr_rsp_if rsp_if ();
	lru_pr_cfg_if cfg_if ();

	lru_page_replacement_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	lru_tracker lru = new();

	// idle percentages per side; zero means a full-rate stretch
	int src_gap  = IDLE_PCT;
	int sink_gap = IDLE_PCT;
	// set by the stimulus, counted down by the receiver
	int stall_hold = 0;
	int settings_seen = 0;

	// working set of page numbers; reused across phases so that shrinking and
	// growing frames_in_use finds stale copies in the frames left out
	logic [PAGE_BITS-1:0] pool [PAGE_POOL];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: random back-pressure, plus the long hold-off on request.
	initial begin : sink_side
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_hold > 0) begin
				stall_hold--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= sink_gap);
			end
		end
	end

	// Every accepted result word is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready)
			lru.check_lookup(rsp_if.hit, rsp_if.frame, rsp_if.evicted_valid,
				rsp_if.evicted_page, rsp_if.fault_count);
	end

	// Hang detector: counts consecutive cycles in which no channel moves a word.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
					|| (cfg_if.valid && cfg_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// Offer one reference and hold it until accepted. valid is left high on
	// return; the caller either offers the next word or drops valid in the
	// same time step.
	task automatic send_page(input logic [PAGE_BITS-1:0] pg);
		while ($urandom_range(99) < src_gap) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.page  <= pg;
		do
			@(posedge clk);
		while (!req_if.ready);
		lru.note_reference(pg);
	endtask

	task automatic send_list(input logic [PAGE_BITS-1:0] pages [$]);
		foreach (pages[i])
			send_page(pages[i]);
	endtask

	// Stop offering and wait for every outstanding result. Each reference
	// yields exactly one word, so an empty queue means the block is idle; the
	// trailing wait is margin only.
	task automatic settle();
		req_if.valid <= 1'b0;
		while (lru.pending() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Only called after settle(): the register is never changed mid-stream.
	task automatic write_frames(input logic [CFG_W-1:0] n);
		cfg_if.valid         <= 1'b1;
		cfg_if.frames_in_use <= n;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		lru.set_frames(n);
		settings_seen++;
	endtask

	// Random references: mostly drawn from a working set a little larger than
	// the active frames, so hits, fills and evictions all occur; some from the
	// whole pool to hit stale frames beyond the limit; some all-zero or all-ones; the rest fully random.
	task automatic random_phase(input int count);
		int width;
		int roll;
		logic [PAGE_BITS-1:0] pg;
		repeat (3) pool[$urandom_range(PAGE_POOL - 1)] = PAGE_BITS'($urandom);
		width = lru.active_frames() + $urandom_range(3);
		if (width > PAGE_POOL)
			width = PAGE_POOL;
		repeat (count) begin
			roll = $urandom_range(99);
			if (roll < 76)
				pg = pool[$urandom_range(width - 1)];
			else if (roll < 86)
				pg = pool[$urandom_range(PAGE_POOL - 1)];
			else if (roll < 88)
				pg = $urandom_range(1) ? '1 : '0;
			else
				pg = PAGE_BITS'($urandom);
			send_page(pg);
		end
	endtask

	initial begin : stimulus
		logic [PAGE_BITS-1:0] seq [$];
		logic [CFG_W-1:0] plan [$];
		arst_n               <= 1'b0;
		req_if.valid         <= 1'b0;
		req_if.page          <= '0;
		cfg_if.valid         <= 1'b0;
		cfg_if.frames_in_use <= '0;
		foreach (pool[i])
			pool[i] = PAGE_BITS'($urandom);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---
		// Reset setting of eight frames. Page zero first: the frames hold
		// zero after reset but are empty, so it must fault, then hit. Fill
		// all eight, then force LRU evictions and one hit.
		seq = '{16'h0000, 16'h0000, 16'hFFFF, 16'h0001, 16'h0002, 16'h0003,
			16'h0004, 16'h0005, 16'h0006, 16'h0007, 16'h0000, 16'hFFFF,
			16'h0006, 16'h8000};
		send_list(seq);

		// Shrink to two frames: pages held only in frames 2..7 now fault,
		// leaving a second copy in the low frames.
		settle();
		write_frames(4'd2);
		seq = '{16'h0005, 16'h0006, 16'h0005};
		send_list(seq);

		// Zero behaves as one frame.
		settle();
		write_frames(4'd0);
		seq = '{16'h0005, 16'h0009};
		send_list(seq);

		// Above the frame count saturates to eight; duplicated pages must
		// resolve to the lowest matching frame.
		settle();
		write_frames(4'd15);
		seq = '{16'h0005, 16'h0006, 16'hAAAA, 16'h5555};
		send_list(seq);

		// --- random part ---
		// Walks through small, full and out-of-range settings; covers every
		// bit of the register both ways.
		plan = '{4'd1, 4'd8, 4'd4, 4'd9, 4'd3, 4'd12, 4'd6, 4'd2, 4'd7,
			4'd5, 4'd15, 4'd0, 4'd8, 4'd10};
		foreach (plan[k]) begin
			settle();
			write_frames(plan[k]);
			if (k == 2) begin
				// long receiver hold-off while the sender keeps pushing, so
				// the output register fills and req goes not-ready
				random_phase(25);
				src_gap = 0;
				stall_hold = HOLDOFF_LEN;
				random_phase(30);
				src_gap = IDLE_PCT;
				random_phase(15);
			end else if (k == 4) begin
				// long stretch at full rate on both sides
				src_gap = 0;
				sink_gap = 0;
				random_phase(120);
				src_gap = IDLE_PCT;
				sink_gap = IDLE_PCT;
			end else if (k == 6) begin
				// sender pauses until the pipe has drained, then resumes
				random_phase(30);
				settle();
				random_phase(35);
			end else begin
				random_phase(60);
			end
		end

		// --- fault after fault ---
		// One frame and two alternating pages: every reference faults and
		// evicts the other page, at full rate on both sides.
		settle();
		write_frames(4'd1);
		src_gap = 0;
		sink_gap = 0;
		for (int i = 0; i < 24; i++)
			send_page(i[0] ? 16'h1234 : 16'hEDCB);
		src_gap = IDLE_PCT;
		sink_gap = IDLE_PCT;
		settle();
		write_frames(4'd8);
		random_phase(20);

		// --- wrap-up ---
		req_if.valid <= 1'b0;
		while (lru.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Checked %0d lookups: %0d hits, %0d evictions, final fault count %0d.",
			lru.checked, lru.hits, lru.evictions, lru.faults);
		$display("Covered %0d frames_in_use writes incl. 0 and 15, plus back-pressure.",
			settings_seen);
		if (lru.mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* lru_page_replacement_unit.f */
+incdir+rtl/core
rtl/core/lru_pr_pkg.sv
rtl/core/lru_pr_if.sv
rtl/core/lru_pr_cell.sv
rtl/core/lru_page_replacement_unit.sv
rtl/core/lru_pr_checker.sv
tb/lru_fault_check_pkg.sv
tb/tb_lru_page_replacement_unit.sv
